// ===== rtl/fpas_pkg.sv =====
package fpas_pkg;

    localparam logic [7:0]  EXP_MAX     = 8'hFF;
    localparam logic [31:0] DEFAULT_NAN = 32'h7FC00000;
    localparam logic [31:0] QUIET_BIT   = 32'h00400000;
    localparam logic        OP_ADD      = 1'b0;
    localparam logic        OP_SUB      = 1'b1;

    // Special-case result travelling beside the arithmetic path
    typedef struct packed {
        logic        special;
        logic [31:0] value;
    } spec_t;

    // Aligned operands after stage 1
    typedef struct packed {
        spec_t       spec;
        logic        sign;
        logic        eff_sub;
        logic [7:0]  exp;
        logic [26:0] xa;
        logic [26:0] xb;
    } align_t;

    // Raw sum after stage 2
    typedef struct packed {
        spec_t       spec;
        logic        sign;
        logic        zero;
        logic [8:0]  exp;
        logic [27:0] mag;
    } sum_t;

    // Normalized mantissa after stage 3
    typedef struct packed {
        spec_t       spec;
        logic        sign;
        logic        zero;
        logic [8:0]  exp;
        logic [26:0] mag;
    } norm_t;

endpackage

// ===== rtl/fpas_align.sv =====
module fpas_align
(
    input  logic [31:0]      operand_a,
    input  logic [31:0]      operand_b,
    input  logic             opcode,
    output fpas_pkg::align_t align
);

    logic        sa, sb, big_s, sml_s;
    logic [7:0]  ea, eb, ea1, eb1, big_e, sml_e, d;
    logic [22:0] fa, fb;
    logic [23:0] ma, mb, big_m, sml_m;
    logic        nan_a, nan_b, inf_a, inf_b, swap;
    logic [26:0] xb_full;
    logic [26:0] lost_mask;
    logic [26:0] shifted;

    // Unpack, check special operands
    always_comb
    begin
        sa = operand_a[31];
        sb = operand_b[31] ^ (opcode == fpas_pkg::OP_SUB);
        ea = operand_a[30:23];
        eb = operand_b[30:23];
        fa = operand_a[22:0];
        fb = operand_b[22:0];
        nan_a = (ea == fpas_pkg::EXP_MAX) && (fa != 23'd0);
        nan_b = (eb == fpas_pkg::EXP_MAX) && (fb != 23'd0);
        inf_a = (ea == fpas_pkg::EXP_MAX) && (fa == 23'd0);
        inf_b = (eb == fpas_pkg::EXP_MAX) && (fb == 23'd0);
        align.spec.special = nan_a || nan_b || inf_a || inf_b;
        if (nan_a)
            align.spec.value = operand_a | fpas_pkg::QUIET_BIT;
        else if (nan_b)
            align.spec.value = operand_b | fpas_pkg::QUIET_BIT;
        else if (inf_a && inf_b && (sa != sb))
            align.spec.value = fpas_pkg::DEFAULT_NAN;
        else if (inf_a)
            align.spec.value = operand_a;
        else
            align.spec.value = {sb, operand_b[30:0]};

        ma  = {ea != 8'd0, fa};
        mb  = {eb != 8'd0, fb};
        ea1 = (ea == 8'd0) ? 8'd1 : ea;
        eb1 = (eb == 8'd0) ? 8'd1 : eb;
        swap = (ea1 < eb1) || ((ea1 == eb1) && (ma < mb));
        big_s = swap ? sb : sa;
        sml_s = swap ? sa : sb;
        big_e = swap ? eb1 : ea1;
        sml_e = swap ? ea1 : eb1;
        big_m = swap ? mb : ma;
        sml_m = swap ? ma : mb;
        d = big_e - sml_e;

        // Shift right with sticky
        xb_full = {sml_m, 3'b000};
        if (d >= 8'd27)
        begin
            shifted   = {26'd0, xb_full != 27'd0};
            lost_mask = '0;
        end
        else
        begin
            lost_mask = ~(27'h7FFFFFF << d[4:0]);
            shifted   = (xb_full >> d[4:0]) | {26'd0, (xb_full & lost_mask) != 27'd0};
        end

        align.sign    = big_s;
        align.eff_sub = big_s != sml_s;
        align.exp     = big_e;
        align.xa      = {big_m, 3'b000};
        align.xb      = shifted;
    end

endmodule

// ===== rtl/fpas_addnorm.sv =====
module fpas_addnorm
(
    input  fpas_pkg::align_t align,
    output fpas_pkg::sum_t   sum
);

    logic [27:0] m;

    // Add or subtract magnitudes
    always_comb
    begin
        if (align.eff_sub)
            m = {1'b0, align.xa} - {1'b0, align.xb};
        else
            m = {1'b0, align.xa} + {1'b0, align.xb};
        sum.spec = align.spec;
        sum.sign = align.sign;
        sum.zero = align.eff_sub && (m == 28'd0);
        sum.exp  = {1'b0, align.exp};
        sum.mag  = m;
    end

endmodule

// ===== rtl/fpas_norm.sv =====
module fpas_norm
(
    input  fpas_pkg::sum_t  sum,
    output fpas_pkg::norm_t norm
);

    logic [4:0]  lz;
    logic [4:0]  sh;
    logic [8:0]  room;
    logic        found;

    // Count leading zeros of the 27-bit mantissa, shift limited by exponent
    always_comb
    begin
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 26; i >= 0; i--)
        begin
            if (!found && sum.mag[i])
            begin
                found = 1'b1;
                lz    = 5'(26 - i);
            end
        end
        room = sum.exp - 9'd1;
        sh   = ({4'd0, lz} > room) ? room[4:0] : lz;

        norm.spec = sum.spec;
        norm.sign = sum.sign;
        norm.zero = sum.zero;
        if (sum.mag[27])
        begin
            norm.mag = sum.mag[27:1] | {26'd0, sum.mag[0]};
            norm.exp = sum.exp + 9'd1;
        end
        else
        begin
            norm.mag = sum.mag[26:0] << sh;
            norm.exp = sum.exp - {4'd0, sh};
        end
    end

endmodule

// ===== rtl/fpas_round.sv =====
module fpas_round
(
    input  fpas_pkg::norm_t norm,
    output logic [31:0]     result
);

    logic [2:0]  rb;
    logic [24:0] m;
    logic [8:0]  e;
    logic        up;

    // Round to nearest even, pack
    always_comb
    begin
        rb = norm.mag[2:0];
        up = (rb > 3'd4) || ((rb == 3'd4) && norm.mag[3]);
        m  = {1'b0, norm.mag[26:3]} + {24'd0, up};
        e  = norm.exp;
        if (m[24])
        begin
            m = m >> 1;
            e = e + 9'd1;
        end
        if (norm.spec.special)
            result = norm.spec.value;
        else if (norm.zero)
            result = 32'd0;
        else if (e >= 9'd255)
            result = {norm.sign, 31'h7F800000};
        else
            result = {norm.sign, (m[23] ? e[7:0] : 8'd0), m[22:0]};
    end

endmodule

// ===== rtl/fp32_add_sub.sv =====
// fp32_add_sub: single-precision add/subtract, round to nearest even.
// Throughput: one transaction per cycle unless a stalled valid output holds it;
// four stages (align, add, normalize, round) each hold one transaction and
// advance together when not stalled.
// Reset: rst_n asynchronously clears all stage valid bits.
module fp32_add_sub
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic        opcode,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result
);

    fpas_pkg::align_t a_comb, a_reg;
    fpas_pkg::sum_t   s_comb, s_reg;
    fpas_pkg::norm_t  n_comb, n_reg;
    logic [31:0]      r_comb, r_reg;
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic             adv;

    // Whole pipe moves unless a valid output is stalled
    assign adv       = !(v4_reg && out_stall);
    assign in_stall  = !adv;
    assign out_valid = v4_reg;
    assign result    = r_reg;

    fpas_align   u_align   (.operand_a(operand_a), .operand_b(operand_b),
                            .opcode(opcode), .align(a_comb));
    fpas_addnorm u_add     (.align(a_reg), .sum(s_comb));
    fpas_norm    u_norm    (.sum(s_reg), .norm(n_comb));
    fpas_round   u_round   (.norm(n_reg), .result(r_comb));

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_comb;
            s_reg <= s_comb;
            n_reg <= n_comb;
            r_reg <= r_comb;
        end
    end

endmodule

// ===== rtl/fp32_add_sub_checker.sv =====
module fp32_add_sub_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result))
        else $error("stalled result changed");

    // Input stall only under output backpressure
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without backpressure");

    // Accepted transaction emerges as a valid result while out_stall stays low behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
        |=> out_valid)
        else $error("result missing");

    // No result appears out of an empty pipe; an idle output keeps the pipe moving
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && $past(!out_valid, 3) && $past(!out_valid, 2) && $past(!out_valid, 1)
        && $past(!in_valid, 3) && $past(!in_valid, 2) && $past(!in_valid, 1)
        && !in_valid |=> !out_valid)
        else $error("invented result");

endmodule

bind fp32_add_sub fp32_add_sub_checker u_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .result(result)
);
